// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on a clock edge and switched off while reset is low.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent assertion sampled on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/pgso_pkg.sv
// Types, constants and codes shared by the sphere overlap block.
`default_nettype none

package pgso_pkg;

  // Default grid geometry.
  localparam int unsigned GRID_SIDE_DEF    = 8;
  localparam int unsigned MAX_PER_CELL_DEF = 8;

  // Coordinate and arithmetic widths.
  localparam int unsigned COORD_W = 24;           // unsigned 16.8
  localparam int unsigned QW      = COORD_W + 2;  // shifted query coordinate, signed
  localparam int unsigned AW      = COORD_W + 1;  // magnitude of a difference or radius sum
  localparam int unsigned SQW     = 2 * AW;       // one square
  localparam int unsigned SUMW    = SQW + 2;      // sum of three squares

  // Item actions.
  typedef enum logic [1:0] {
    ACT_CHECK        = 2'd0,
    ACT_INSERT       = 2'd1,
    ACT_CHECK_INSERT = 2'd2,
    ACT_CLEAR        = 2'd3
  } action_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_BOX_LENGTH = 1'b0,
    REG_ONLY_OTHER = 1'b1
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_NB_RD,
    S_NB_CNT,
    S_SCAN,
    S_DRAIN,
    S_INS_RD,
    S_INS_WR,
    S_DONE
  } state_e;

  // Neighbour offset codes along one axis: one below, same, one above.
  localparam logic [1:0] OFF_LO = 2'd0;
  localparam logic [1:0] OFF_HI = 2'd2;

  // One stored sphere.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] r;
  } sphere_t;

  // Query as seen from one neighbour cell, with the periodic shift applied.
  typedef struct packed {
    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] qy;
    logic signed [QW-1:0] qz;
    logic [COORD_W-1:0]   qr;
    logic                 oor;
  } query_t;

endpackage

`default_nettype wire

// File: rtl/core/pgso_dist.sv
// Three-stage distance pipeline that tests one stored sphere per cycle.
`default_nettype none

module pgso_dist (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              issue_i,
  input  pgso_pkg::query_t  qry_i,
  input  pgso_pkg::sphere_t sph_i,
  output logic              hit_o,
  output logic              busy_o
);
  import pgso_pkg::*;

  logic             v1_q, v2_q, v3_q;
  query_t           qa_q;
  logic [AW-1:0]    ax_q, ay_q, az_q, lim_q;
  logic [SQW-1:0]   sx_q, sy_q, sz_q, sl_q;
  logic [SUMW-1:0]  dist_sum;

  // Magnitude of the difference between a shifted query coordinate and a stored one.
  function automatic logic [AW-1:0] abs_diff(logic signed [QW-1:0] q,
                                             logic [COORD_W-1:0] s);
    logic signed [QW:0] d;
    d = $signed({q[QW-1], q}) - $signed({3'b000, s});
    return d[QW] ? AW'(-d) : AW'(d);
  endfunction

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // The query travels with the memory read; the stored sphere arrives in the cycle after.
  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      qa_q <= qry_i;
    end
    if (v1_q) begin
      ax_q  <= abs_diff(qa_q.qx, sph_i.x);
      ay_q  <= abs_diff(qa_q.qy, sph_i.y);
      az_q  <= abs_diff(qa_q.qz, sph_i.z);
      lim_q <= qa_q.oor ? {1'b0, sph_i.r} : {1'b0, qa_q.qr} + {1'b0, sph_i.r};
    end
    if (v2_q) begin
      sx_q <= ax_q * ax_q;
      sy_q <= ay_q * ay_q;
      sz_q <= az_q * az_q;
      sl_q <= lim_q * lim_q;
    end
  end

  // Final compare: strictly inside the limit counts as an overlap.
  assign dist_sum = SUMW'(sx_q) + SUMW'(sy_q) + SUMW'(sz_q);
  assign hit_o    = v3_q && (dist_sum < SUMW'(sl_q));
  assign busy_o   = v1_q | v2_q | v3_q;

endmodule

`default_nettype wire

// File: rtl/core/periodic_grid_sphere_overlap_core.sv
// Top level of the periodic cell-list sphere overlap block.
//
// Usage: items enter on the in channel (valid/ready) and each gives exactly one
// result beat on the out channel (valid/ready): a collision flag and a status bit.
// Configuration (box length, only-other-radius mode) is written through a plain
// write port; the user must write it only while the block is idle, which the
// block does not enforce; it then takes effect on the next item. A check walks
// the 27 neighbour cells; for each it reads the cell's count (S_NB_RD, then
// S_NB_CNT), then its stored spheres one per cycle, and at the end it waits
// for the distance pipeline to drain. An insert reads the home cell's count
// (S_INS_RD), then writes the sphere and new count (S_INS_WR); a check then
// insert does so after a check with no overlap. A clear sweeps the count
// memory, one cell a cycle; after reset one sweep runs before in_ready_o rises.
// The next item is accepted while a result waits; if the receiver stalls, that
// item finishes its work and then holds until the waiting result is taken.
`default_nettype none

module periodic_grid_sphere_overlap_core #(
  parameter int unsigned GRID_SIDE    = pgso_pkg::GRID_SIDE_DEF,
  parameter int unsigned MAX_PER_CELL = pgso_pkg::MAX_PER_CELL_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [pgso_pkg::COORD_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  logic [2:0]                   cell_i_i,
  input  logic [2:0]                   cell_j_i,
  input  logic [2:0]                   cell_k_i,
  input  logic [pgso_pkg::COORD_W-1:0] pos_x_i,
  input  logic [pgso_pkg::COORD_W-1:0] pos_y_i,
  input  logic [pgso_pkg::COORD_W-1:0] pos_z_i,
  input  logic [pgso_pkg::COORD_W-1:0] radius_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         collision_o,
  output logic                         status_o
);
  import pgso_pkg::*;

  localparam int unsigned CW        = $clog2(GRID_SIDE);
  localparam int unsigned NUM_CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int unsigned CAW       = $clog2(NUM_CELLS);
  localparam int unsigned SW        = (MAX_PER_CELL > 1) ? $clog2(MAX_PER_CELL) : 1;
  localparam int unsigned NW        = $clog2(MAX_PER_CELL + 1);
  localparam int unsigned SPH_DEPTH = NUM_CELLS << SW;

  typedef struct packed {
    logic [CW-1:0]        idx;
    logic signed [QW-1:0] q;
  } axis_t;

  // Control state.
  state_e               state_q, state_d;
  action_e              act_q, act_d;
  logic                 clr_item_q, clr_item_d;
  logic [CAW-1:0]       sweep_q, sweep_d;
  logic [1:0]           na_q, na_d, nb_q, nb_d, nc_q, nc_d;
  logic [SW-1:0]        slot_q, slot_d;
  logic [NW-1:0]        cell_cnt_q, cell_cnt_d;
  logic [CAW-1:0]       cur_cell_q, cur_cell_d;
  logic                 hit_q, hit_d;
  logic                 stat_q, stat_d;
  logic                 out_valid_q, out_valid_d;
  logic [COORD_W-1:0]   box_q;
  logic                 oor_q;

  // Item payload and result registers.
  logic [CW-1:0]        ci_q, cj_q, ck_q;
  logic [COORD_W-1:0]   px_q, py_q, pz_q, pr_q;
  query_t               qry_q, qry_d;
  logic                 coll_out_q, stat_out_q;

  // Memory ports.
  logic [NW-1:0]        cnt_mem [NUM_CELLS];
  logic [NW-1:0]        cnt_rd_q;
  logic                 cnt_we, cnt_re;
  logic [CAW-1:0]       cnt_waddr, cnt_raddr;
  logic [NW-1:0]        cnt_wdata;
  sphere_t              sph_mem [SPH_DEPTH];
  sphere_t              sph_rd_q;
  logic                 sph_we, sph_re;
  logic [CAW+SW-1:0]    sph_addr;

  // Walk helpers.
  axis_t                wx, wy, wz;
  logic [CAW-1:0]       nb_cell, home_cell;
  logic                 nb_last, slot_last, load_out;
  logic [5:0]           nb_next;
  logic                 dist_hit, dist_busy;

  // Cell index reduced modulo the grid side; inputs never reach three sides.
  function automatic logic [CW-1:0] red_idx(logic [2:0] v);
    logic [7:0] w;
    w = {5'b00000, v};
    if (w >= 8'(2 * GRID_SIDE)) begin
      w = w - 8'(2 * GRID_SIDE);
    end else if (w >= 8'(GRID_SIDE)) begin
      w = w - 8'(GRID_SIDE);
    end
    return w[CW-1:0];
  endfunction

  function automatic logic [CAW-1:0] cell_addr(logic [CW-1:0] i, logic [CW-1:0] j,
                                               logic [CW-1:0] k);
    return (CAW'(i) * CAW'(GRID_SIDE) + CAW'(j)) * CAW'(GRID_SIDE) + CAW'(k);
  endfunction

  // Neighbour index along one axis, wrapping at the faces and shifting the query.
  function automatic axis_t wrap_ax(logic [CW-1:0] c, logic [1:0] off,
                                    logic [COORD_W-1:0] p, logic [COORD_W-1:0] box);
    axis_t                r;
    logic signed [QW-1:0] base;
    logic signed [QW-1:0] bx;
    base  = $signed({2'b00, p});
    bx    = $signed({2'b00, box});
    r.idx = c;
    r.q   = base;
    if (off == OFF_LO) begin
      if (c == '0) begin
        r.idx = CW'(GRID_SIDE - 1);
        r.q   = base + bx;
      end else begin
        r.idx = c - CW'(1);
      end
    end else if (off == OFF_HI) begin
      if (c == CW'(GRID_SIDE - 1)) begin
        r.idx = '0;
        r.q   = base - bx;
      end else begin
        r.idx = c + CW'(1);
      end
    end
    return r;
  endfunction

  // Current neighbour cell and shifted query.
  always_comb begin
    wx        = wrap_ax(ci_q, na_q, px_q, box_q);
    wy        = wrap_ax(cj_q, nb_q, py_q, box_q);
    wz        = wrap_ax(ck_q, nc_q, pz_q, box_q);
    nb_cell   = cell_addr(wx.idx, wy.idx, wz.idx);
    home_cell = cell_addr(ci_q, cj_q, ck_q);
    qry_d.qx  = wx.q;
    qry_d.qy  = wy.q;
    qry_d.qz  = wz.q;
    qry_d.qr  = pr_q;
    qry_d.oor = oor_q;
  end

  // Neighbour counter advance, innermost axis z.
  always_comb begin
    nb_last = (na_q == OFF_HI) && (nb_q == OFF_HI) && (nc_q == OFF_HI);
    nb_next = {na_q, nb_q, nc_q + 2'd1};
    if (nc_q == OFF_HI) begin
      nb_next = {na_q, nb_q + 2'd1, OFF_LO};
      if (nb_q == OFF_HI) begin
        nb_next = {na_q + 2'd1, OFF_LO, OFF_LO};
      end
    end
    slot_last = (NW'(slot_q) + NW'(1)) == cell_cnt_q;
  end

  // Sequencer: next state, memory controls and handshakes.
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    clr_item_d  = clr_item_q;
    sweep_d     = sweep_q;
    na_d        = na_q;
    nb_d        = nb_q;
    nc_d        = nc_q;
    slot_d      = slot_q;
    cell_cnt_d  = cell_cnt_q;
    cur_cell_d  = cur_cell_q;
    hit_d       = hit_q | dist_hit;
    stat_d      = stat_q;
    cnt_we      = 1'b0;
    cnt_waddr   = sweep_q;
    cnt_wdata   = '0;
    cnt_re      = 1'b0;
    cnt_raddr   = nb_cell;
    sph_we      = 1'b0;
    sph_re      = 1'b0;
    sph_addr    = {cur_cell_q, slot_q};
    load_out    = 1'b0;
    in_ready_o  = 1'b0;

    unique case (state_q)
      S_SWEEP: begin
        cnt_we = 1'b1;
        if (sweep_q == CAW'(NUM_CELLS - 1)) begin
          state_d = clr_item_q ? S_DONE : S_IDLE;
        end else begin
          sweep_d = sweep_q + CAW'(1);
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d      = action_e'(action_i);
          hit_d      = 1'b0;
          stat_d     = 1'b0;
          na_d       = OFF_LO;
          nb_d       = OFF_LO;
          nc_d       = OFF_LO;
          sweep_d    = '0;
          clr_item_d = 1'b0;
          unique case (action_e'(action_i))
            ACT_CLEAR: begin
              clr_item_d = 1'b1;
              state_d    = S_SWEEP;
            end
            ACT_INSERT:       state_d = S_INS_RD;
            ACT_CHECK:        state_d = S_NB_RD;
            ACT_CHECK_INSERT: state_d = S_NB_RD;
            default:          state_d = S_NB_RD;
          endcase
        end
      end
      S_NB_RD: begin
        cnt_re     = 1'b1;
        cur_cell_d = nb_cell;
        state_d    = S_NB_CNT;
      end
      S_NB_CNT: begin
        cell_cnt_d = cnt_rd_q;
        slot_d     = '0;
        if (cnt_rd_q != '0) begin
          state_d = S_SCAN;
        end else if (nb_last) begin
          state_d = S_DRAIN;
        end else begin
          {na_d, nb_d, nc_d} = nb_next;
          state_d            = S_NB_RD;
        end
      end
      S_SCAN: begin
        sph_re = 1'b1;
        if (!slot_last) begin
          slot_d = slot_q + SW'(1);
        end else if (nb_last) begin
          state_d = S_DRAIN;
        end else begin
          {na_d, nb_d, nc_d} = nb_next;
          state_d            = S_NB_RD;
        end
      end
      S_DRAIN: begin
        if (!dist_busy) begin
          state_d = (act_q == ACT_CHECK_INSERT && !hit_q) ? S_INS_RD : S_DONE;
        end
      end
      S_INS_RD: begin
        cnt_re    = 1'b1;
        cnt_raddr = home_cell;
        state_d   = S_INS_WR;
      end
      S_INS_WR: begin
        if (cnt_rd_q >= NW'(MAX_PER_CELL)) begin
          stat_d = 1'b1;
        end else begin
          sph_we    = 1'b1;
          sph_addr  = {home_cell, cnt_rd_q[SW-1:0]};
          cnt_we    = 1'b1;
          cnt_waddr = home_cell;
          cnt_wdata = cnt_rd_q + NW'(1);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = load_out | (out_valid_q & ~out_ready_i);
  end

  // Control registers; reset starts the count sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      act_q       <= ACT_CHECK;
      clr_item_q  <= 1'b0;
      sweep_q     <= '0;
      na_q        <= OFF_LO;
      nb_q        <= OFF_LO;
      nc_q        <= OFF_LO;
      slot_q      <= '0;
      cell_cnt_q  <= '0;
      cur_cell_q  <= '0;
      hit_q       <= 1'b0;
      stat_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      clr_item_q  <= clr_item_d;
      sweep_q     <= sweep_d;
      na_q        <= na_d;
      nb_q        <= nb_d;
      nc_q        <= nc_d;
      slot_q      <= slot_d;
      cell_cnt_q  <= cell_cnt_d;
      cur_cell_q  <= cur_cell_d;
      hit_q       <= hit_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '1;
      oor_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BOX_LENGTH: box_q <= cfg_wdata_i;
        REG_ONLY_OTHER: oor_q <= cfg_wdata_i[0];
        default:        oor_q <= oor_q;
      endcase
    end
  end

  // Item payload, query and result beat registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ci_q <= red_idx(cell_i_i);
      cj_q <= red_idx(cell_j_i);
      ck_q <= red_idx(cell_k_i);
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
      pr_q <= radius_i;
    end
    if (state_q == S_NB_RD) begin
      qry_q <= qry_d;
    end
    if (load_out) begin
      coll_out_q <= hit_q;
      stat_out_q <= stat_q;
    end
  end

  // Per-cell count memory, registered read.
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_raddr];
    end
  end

  // Sphere store, one slot row per cell, registered read.
  always_ff @(posedge clk_i) begin
    if (sph_we) begin
      sph_mem[sph_addr] <= '{x: px_q, y: py_q, z: pz_q, r: pr_q};
    end
    if (sph_re) begin
      sph_rd_q <= sph_mem[sph_addr];
    end
  end

  pgso_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (sph_re),
    .qry_i   (qry_q),
    .sph_i   (sph_rd_q),
    .hit_o   (dist_hit),
    .busy_o  (dist_busy)
  );

  assign out_valid_o = out_valid_q;
  assign collision_o = coll_out_q;
  assign status_o    = stat_out_q;

endmodule

`default_nettype wire

// File: rtl/core/pgso_checker.sv
// Port-level checker for the sphere overlap block, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module pgso_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic collision_o,
  input logic status_o
);

  // A result beat waits for the receiver.
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result beat dropped while stalled")

  // Once reset has been seen low, nothing is offered or taken on the following cycle.
  `ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> (!out_valid_o && !in_ready_o), "handshake active in reset")

  // An accepted item occupies the block for at least the following cycle.
  `ASSERT_RST(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "second item accepted at once")

  // A refused insert never follows a detected overlap.
  `ASSERT_RST(a_coll_status, clk_i, rst_ni, out_valid_o |-> !(collision_o && status_o), "collision and refusal together")

endmodule

bind periodic_grid_sphere_overlap_core pgso_checker u_pgso_checker (.*);

`default_nettype wire
